FILE: design/tsqb_pkg.sv
// package for the threshold select quintic blend block
// shared constants: fraction format, config register indexes, pipeline latency
// no dependencies
package tsqb_pkg;

  // blend factor is unsigned q0.16 with one extra bit so that 1.0 is exact
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned Q_BITS    = FRAC_BITS + 1;
  localparam int unsigned FRAC_ONE  = 1 << FRAC_BITS;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALLOFF   = 2'd1;

  // clock edges from the input transfer to the edge that takes the result
  localparam int unsigned LATENCY = 26;

endpackage

FILE: design/tsqb_div.sv
// pipelined restoring divider for the blend factor, one quotient bit per stage
// gives floor(dividend * 2^16 / divisor) for dividend <= divisor; uses tsqb_pkg
module tsqb_div #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned SIDE_W = 34
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  logic [WIDTH-1:0]              in_dividend,
  input  logic [WIDTH-1:0]              divisor,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_vld,
  output logic [tsqb_pkg::Q_BITS-1:0]   out_quot,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int unsigned STAGES = tsqb_pkg::Q_BITS;

  logic                        vld_r  [STAGES];
  logic [WIDTH-1:0]            rem_r  [STAGES];
  logic [tsqb_pkg::Q_BITS-1:0] quo_r  [STAGES];
  logic [SIDE_W-1:0]           side_r [STAGES];

  // top quotient bit: set when the dividend is at least the divisor, so for dividend <= divisor only on equality
  logic             ge0;
  logic [WIDTH-1:0] rem0_nxt;

  assign ge0      = (in_dividend >= divisor);
  assign rem0_nxt = ge0 ? (in_dividend - divisor) : in_dividend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0]  <= rem0_nxt;
    quo_r[0]  <= {{(tsqb_pkg::Q_BITS-1){1'b0}}, ge0};
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k < STAGES; k++) begin : g_stage
    logic [WIDTH:0] rem2;
    logic [WIDTH:0] sub;
    logic           ge;

    assign rem2 = {rem_r[k-1], 1'b0};
    assign sub  = rem2 - {1'b0, divisor};
    assign ge   = (rem2 >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      // remainder stays below the divisor, so the top bit drops
      rem_r[k]  <= ge ? sub[WIDTH-1:0] : rem2[WIDTH-1:0];
      quo_r[k]  <= {quo_r[k-1][tsqb_pkg::Q_BITS-2:0], ge};
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_quot = quo_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

FILE: design/threshold_select_quintic_blend.sv
// throughput: one item per cycle; the depth comes from the classify stage, the 17-stage
// divider, the chain of four power multipliers and the polynomial, blend multiply,
// rounding and output stages
// busy stays low: the pipeline never stalls, results cannot be held off
// reset (synchronous, rst_n low) clears all valid bits and sets both config registers to 0
// uses tsqb_pkg and tsqb_div
module threshold_select_quintic_blend #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [SAMPLE_BITS-1:0]       in_control_value,
  input  logic signed [SAMPLE_BITS-1:0]       in_low_value,
  input  logic signed [SAMPLE_BITS-1:0]       in_high_value,
  output logic                                out_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_result_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsqb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [SAMPLE_BITS-1:0]              cfg_data
);

  localparam int unsigned N  = SAMPLE_BITS;
  localparam int unsigned QB = tsqb_pkg::Q_BITS;
  localparam int unsigned FB = tsqb_pkg::FRAC_BITS;
  localparam int unsigned PW = 2 * QB;
  localparam int unsigned SW = 23;
  localparam int unsigned MW = N + QB + 2;

  typedef struct packed {
    logic                  pick_hi;
    logic                  blend;
    logic signed [N-1:0]   lo;
    logic signed [N-1:0]   hi;
  } side_t;

  // config registers
  logic signed [N-1:0] threshold_r;
  logic [N-2:0]        falloff_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      falloff_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tsqb_pkg::REG_THRESHOLD: threshold_r <= cfg_data;
        tsqb_pkg::REG_FALLOFF:   falloff_r   <= cfg_data[N-2:0];
        default: ;
      endcase
    end
  end

  // classify the control sample against the band, never wrapping the bounds
  logic signed [N+1:0] c_x, th_x, f_x, lower_x, upper_x, d_x;
  logic                f_zero, below, above;
  side_t               side_nxt;

  assign c_x     = {{2{in_control_value[N-1]}}, in_control_value};
  assign th_x    = {{2{threshold_r[N-1]}}, threshold_r};
  assign f_x     = {3'b000, falloff_r};
  assign lower_x = th_x - f_x;
  assign upper_x = th_x + f_x;
  assign d_x     = c_x - lower_x;
  assign f_zero  = (falloff_r == '0);
  assign below   = (c_x < lower_x);
  assign above   = (c_x > upper_x);

  always_comb begin
    side_nxt.lo      = in_low_value;
    side_nxt.hi      = in_high_value;
    side_nxt.blend   = !f_zero && !below && !above;
    side_nxt.pick_hi = f_zero ? !(in_control_value < threshold_r) : above;
  end

  logic         p0_vld_r;
  side_t        p0_side_r;
  logic [N-1:0] p0_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= start && !busy;
    end
    p0_side_r <= side_nxt;
    p0_d_r    <= d_x[N-1:0];
  end

  // t = (c - lower) * 2^16 / (2 * falloff)
  logic                  dv_vld;
  logic [QB-1:0]         dv_quot;
  logic [$bits(side_t)-1:0] dv_side_bits;
  side_t                 dv_side;

  tsqb_div #(
    .WIDTH  (N),
    .SIDE_W ($bits(side_t))
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (p0_vld_r),
    .in_dividend (p0_d_r),
    .divisor     ({falloff_r, 1'b0}),
    .in_side     (p0_side_r),
    .out_vld     (dv_vld),
    .out_quot    (dv_quot),
    .out_side    (dv_side_bits)
  );

  assign dv_side = side_t'(dv_side_bits);

  // powers of t, one multiply per stage, each floored back to q0.16
  logic          m2_vld_r, m3_vld_r, m4_vld_r, m5_vld_r;
  side_t         m2_side_r, m3_side_r, m4_side_r, m5_side_r;
  logic [QB-1:0] m2_t_r, m2_t2_r;
  logic [QB-1:0] m3_t_r, m3_t3_r;
  logic [QB-1:0] m4_t_r, m4_t3_r, m4_t4_r;
  logic [QB-1:0] m5_t3_r, m5_t4_r, m5_t5_r;
  logic [PW-1:0] t2_prod, t3_prod, t4_prod, t5_prod;

  assign t2_prod = PW'(dv_quot) * PW'(dv_quot);
  assign t3_prod = PW'(m2_t2_r) * PW'(m2_t_r);
  assign t4_prod = PW'(m3_t3_r) * PW'(m3_t_r);
  assign t5_prod = PW'(m4_t4_r) * PW'(m4_t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
      m4_vld_r <= 1'b0;
      m5_vld_r <= 1'b0;
    end else begin
      m2_vld_r <= dv_vld;
      m3_vld_r <= m2_vld_r;
      m4_vld_r <= m3_vld_r;
      m5_vld_r <= m4_vld_r;
    end
    m2_side_r <= dv_side;
    m2_t_r    <= dv_quot;
    m2_t2_r   <= t2_prod[FB+QB-1:FB];
    m3_side_r <= m2_side_r;
    m3_t_r    <= m2_t_r;
    m3_t3_r   <= t3_prod[FB+QB-1:FB];
    m4_side_r <= m3_side_r;
    m4_t_r    <= m3_t_r;
    m4_t3_r   <= m3_t3_r;
    m4_t4_r   <= t4_prod[FB+QB-1:FB];
    m5_side_r <= m4_side_r;
    m5_t3_r   <= m4_t3_r;
    m5_t4_r   <= m4_t4_r;
    m5_t5_r   <= t5_prod[FB+QB-1:FB];
  end

  // s = 6t^5 - 15t^4 + 10t^3, clamped to 0..1
  logic signed [SW-1:0] poly;
  logic [QB-1:0]        s_nxt;
  logic signed [N:0]    diff_nxt;

  assign poly = $signed(SW'(m5_t5_r)) * 23'sd6
              - $signed(SW'(m5_t4_r)) * 23'sd15
              + $signed(SW'(m5_t3_r)) * 23'sd10;

  always_comb begin
    if (poly < 0) begin
      s_nxt = '0;
    end else if (poly > $signed(SW'(tsqb_pkg::FRAC_ONE))) begin
      s_nxt = QB'(tsqb_pkg::FRAC_ONE);
    end else begin
      s_nxt = poly[QB-1:0];
    end
  end

  assign diff_nxt = {m5_side_r.hi[N-1], m5_side_r.hi} - {m5_side_r.lo[N-1], m5_side_r.lo};

  logic              sp_vld_r;
  side_t             sp_side_r;
  logic [QB-1:0]     sp_s_r;
  logic signed [N:0] sp_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_vld_r <= 1'b0;
    end else begin
      sp_vld_r <= m5_vld_r;
    end
    sp_side_r <= m5_side_r;
    sp_s_r    <= s_nxt;
    sp_diff_r <= diff_nxt;
  end

  // blend multiply
  logic signed [MW-1:0] prod_nxt;

  assign prod_nxt = $signed({1'b0, sp_s_r}) * sp_diff_r;

  logic                 pm_vld_r;
  side_t                pm_side_r;
  logic signed [MW-1:0] pm_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_vld_r <= 1'b0;
    end else begin
      pm_vld_r <= sp_vld_r;
    end
    pm_side_r <= sp_side_r;
    pm_prod_r <= prod_nxt;
  end

  // divide by 2^16 truncating toward zero: bias negatives before the shift
  logic [MW-1:0]        bias;
  logic signed [MW-1:0] biased;

  assign bias   = {{(MW-FB){1'b0}}, {FB{pm_prod_r[MW-1]}}};
  assign biased = pm_prod_r + $signed(bias);

  logic                 qt_vld_r;
  side_t                qt_side_r;
  logic signed [N+2:0]  qt_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_vld_r <= 1'b0;
    end else begin
      qt_vld_r <= pm_vld_r;
    end
    qt_side_r <= pm_side_r;
    qt_q_r    <= biased[MW-1:FB];
  end

  // add to low sample, saturate, and pick
  logic signed [N+3:0] sum;
  logic signed [N-1:0] sat;
  logic signed [N-1:0] result_nxt;

  assign sum = {{4{qt_side_r.lo[N-1]}}, qt_side_r.lo} + {qt_q_r[N+2], qt_q_r};

  always_comb begin
    if (sum[N+3:N-1] == '0 || sum[N+3:N-1] == '1) begin
      sat = sum[N-1:0];
    end else if (sum[N+3]) begin
      sat = {1'b1, {(N-1){1'b0}}};
    end else begin
      sat = {1'b0, {(N-1){1'b1}}};
    end
    if (qt_side_r.blend) begin
      result_nxt = sat;
    end else if (qt_side_r.pick_hi) begin
      result_nxt = qt_side_r.hi;
    end else begin
      result_nxt = qt_side_r.lo;
    end
  end

  logic                out_valid_r;
  logic signed [N-1:0] out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= qt_vld_r;
    end
    out_result_r <= result_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;

endmodule

FILE: design/tsqb_chk.sv
// port-level checker for threshold_select_quintic_blend, bound to the top level
// uses tsqb_pkg for latency and register indexes
module tsqb_chk #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic signed [SAMPLE_BITS-1:0]     in_control_value,
  input logic signed [SAMPLE_BITS-1:0]     in_low_value,
  input logic signed [SAMPLE_BITS-1:0]     in_high_value,
  input logic                              out_valid,
  input logic signed [SAMPLE_BITS-1:0]     out_result_value,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [tsqb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [SAMPLE_BITS-1:0]            cfg_data
);

  localparam int unsigned LAT = tsqb_pkg::LATENCY;

  logic [5:0]                    warm_r;
  logic                          warm;
  logic signed [SAMPLE_BITS-1:0] thr_r;
  logic [SAMPLE_BITS-2:0]        fall_r;
  logic                          accept;

  assign accept = start && !busy;
  assign warm   = (warm_r == 6'(LAT));

  // edges since reset, so the latency checks look only at real transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
      thr_r  <= '0;
      fall_r <= '0;
    end else begin
      if (!warm) begin
        warm_r <= warm_r + 6'd1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsqb_pkg::REG_THRESHOLD: thr_r  <= cfg_data;
          tsqb_pkg::REG_FALLOFF:   fall_r <= cfg_data[SAMPLE_BITS-2:0];
          default: ;
        endcase
      end
    end
  end

  // one result per transfer, at a fixed distance
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(accept, LAT)))
    else $error("result strobe does not match transfer at fixed latency");

  // hard switch picks one of the two samples by a plain compare
  a_hard_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid && fall_r == '0) |->
      (($past(in_control_value, LAT) < thr_r &&
        out_result_value == $past(in_low_value, LAT)) ||
       (!($past(in_control_value, LAT) < thr_r) &&
        out_result_value == $past(in_high_value, LAT))))
    else $error("hard switch result is not the expected sample");

  // a result, blended or picked, never leaves the span between the two samples
  a_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid) |->
      ((out_result_value >= $past(in_low_value, LAT) &&
        out_result_value <= $past(in_high_value, LAT)) ||
       (out_result_value <= $past(in_low_value, LAT) &&
        out_result_value >= $past(in_high_value, LAT))))
    else $error("result outside the span of low and high samples");

endmodule

bind threshold_select_quintic_blend tsqb_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsqb_chk (.*);
